[sv/ndt_pkg.sv]
// ----------------------------------------------------------------------------
// ndt_pkg: shared constants and types for the name keyed directory table
// Table geometry, request codes, and the probe and commit records passed
// between the controller and the row of slot cells.
// ----------------------------------------------------------------------------
package ndt_pkg;

   localparam int TABLE_SLOTS = 64;
   localparam int NAME_BYTES  = 8;
   localparam int SECTOR_BITS = 16;

   localparam int NAME_W   = 8 * NAME_BYTES;
   localparam int SLOT_W   = $clog2(TABLE_SLOTS);
   localparam int CNT_W    = $clog2(TABLE_SLOTS + 1);
   localparam int ACTIVE_W = 7;

   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 7'd64;

   localparam logic [1:0] OP_FIND   = 2'd0;
   localparam logic [1:0] OP_ADD    = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;

   // Search token walking down the row, one cell per cycle.
   typedef struct packed {
      logic                   valid;
      logic [NAME_W-1:0]      key;
      logic [CNT_W-1:0]       remaining;  // live slots not yet visited
      logic                   hit;
      logic [SLOT_W-1:0]      hit_slot;
      logic [SECTOR_BITS-1:0] hit_sector;
      logic                   free_found;
      logic [SLOT_W-1:0]      free_slot;
   } probe_type;

   // State update broadcast to all cells once the scan is resolved.
   typedef struct packed {
      logic                   en;
      logic                   fill;       // 1: occupy slot, 0: release slot
      logic [SLOT_W-1:0]      slot;
      logic [NAME_W-1:0]      key;
      logic [SECTOR_BITS-1:0] sector;
      logic                   kind;
   } commit_type;

endpackage

[sv/ndt_cell.sv]
// ----------------------------------------------------------------------------
// ndt_cell: one directory slot
// Holds the slot entry, checks the passing probe against it, and forwards
// the updated probe to the next cell on every clock.
// ----------------------------------------------------------------------------
module ndt_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [ndt_pkg::SLOT_W-1:0] cell_slot,
   input  ndt_pkg::probe_type       up_probe,
   input  ndt_pkg::commit_type      commit,
   output ndt_pkg::probe_type       dn_probe
);
   import ndt_pkg::*;

   logic                   valid_ff;
   logic [NAME_W-1:0]      name_ff;
   logic [SECTOR_BITS-1:0] sector_ff;
   logic                   kind_ff;
   probe_type              probe_ff;
   probe_type              probe_in;
   logic                   live;
   logic                   match;
   logic                   mine;

   assign mine = commit.en && (commit.slot == cell_slot);

   always_comb begin
      probe_in = up_probe;
      live     = (up_probe.remaining != '0);
      match    = live && valid_ff && (name_ff == up_probe.key);
      if (match && !up_probe.hit) begin
         probe_in.hit        = 1'b1;
         probe_in.hit_slot   = cell_slot;
         probe_in.hit_sector = sector_ff;
      end
      if (live && !valid_ff && !up_probe.free_found) begin
         probe_in.free_found = 1'b1;
         probe_in.free_slot  = cell_slot;
      end
      probe_in.remaining = live ? (up_probe.remaining - CNT_W'(1)) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= 1'b0;
         probe_ff.valid <= 1'b0;
      end else begin
         probe_ff.valid <= probe_in.valid;
         if (mine) begin
            valid_ff <= commit.fill;
         end
      end
   end

   always_ff @(posedge clock) begin
      probe_ff.key        <= probe_in.key;
      probe_ff.remaining  <= probe_in.remaining;
      probe_ff.hit        <= probe_in.hit;
      probe_ff.hit_slot   <= probe_in.hit_slot;
      probe_ff.hit_sector <= probe_in.hit_sector;
      probe_ff.free_found <= probe_in.free_found;
      probe_ff.free_slot  <= probe_in.free_slot;
      if (mine && commit.fill) begin
         name_ff   <= commit.key;
         sector_ff <= commit.sector;
         kind_ff   <= commit.kind;
      end
   end

   assign dn_probe = probe_ff;

endmodule

[sv/name_keyed_directory_table.sv]
// ----------------------------------------------------------------------------
// name_keyed_directory_table: directory lookup table searched by name
// Find, add and remove of named entries over a row of slot cells scanned
// by a single probe, with a broadcast update once the scan is resolved.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  req       in         req_valid/ready    req_type, name_key, sector_in, entry_kind
//  rsp       out        rsp_valid/ready    success, sector_out, slot_index
//  csr       in         csr_we             csr_wdata (active_entries)
//
//  From acceptance to response the probe crosses one slot cell per cycle,
//  from the head register through the row of slot cells into the result register.
//  One transaction is in flight; req_ready is high from the response load
//  until the next acceptance, even with that response still waiting on rsp_ready.
//  A stalled response holds the table update back until it can be loaded.
//  Synchronous reset clears all slot valid bits at once; no clearing pass.
// ----------------------------------------------------------------------------
module name_keyed_directory_table (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_type,
   input  logic [63:0]                   req_name_key,
   input  logic [15:0]                   req_sector_in,
   input  logic                          req_entry_kind,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_success,
   output logic [15:0]                   rsp_sector_out,
   output logic [5:0]                    rsp_slot_index,
   input  logic                          csr_we,
   input  logic [ndt_pkg::ACTIVE_W-1:0]  csr_wdata
);
   import ndt_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic [ACTIVE_W-1:0]    active_ff;
   logic [1:0]             op_ff;
   logic [SECTOR_BITS-1:0] sec_ff;
   logic                   kind_ff;
   probe_type              head_ff, head_in;
   probe_type              res_ff;
   probe_type              chain [TABLE_SLOTS+1];
   commit_type             commit;
   logic                   rsp_valid_ff;
   logic                   rsp_success_ff;
   logic [15:0]            rsp_sector_ff;
   logic [5:0]             rsp_slot_ff;
   logic                   accept;
   logic                   rsp_free;
   logic                   finish;
   logic [CNT_W-1:0]       live_cnt;
   logic [31:0]            sec_in_wide;
   logic [31:0]            sec_out_wide;
   logic [31:0]            slot_wide;
   logic                   ok;
   logic [SECTOR_BITS-1:0] ok_sector;
   logic [SLOT_W-1:0]      ok_slot;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign finish    = (state_ff == ST_DONE) && rsp_free;

   assign live_cnt    = (32'(active_ff) > TABLE_SLOTS) ? CNT_W'(TABLE_SLOTS)
                                                      : CNT_W'(active_ff);
   assign sec_in_wide = 32'(req_sector_in);

   always_comb begin
      head_in            = head_ff;
      head_in.valid      = accept;
      head_in.key        = req_name_key[NAME_W-1:0];
      head_in.remaining  = live_cnt;
      head_in.hit        = 1'b0;
      head_in.hit_slot   = '0;
      head_in.hit_sector = '0;
      head_in.free_found = 1'b0;
      head_in.free_slot  = '0;
   end

   assign chain[0] = head_ff;

   for (genvar i = 0; i < TABLE_SLOTS; i++) begin : g_cell
      ndt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_slot (SLOT_W'(i)),
         .up_probe  (chain[i]),
         .commit    (commit),
         .dn_probe  (chain[i+1])
      );
   end

   // Resolve the finished scan into a response and a table update.
   always_comb begin
      ok          = 1'b0;
      ok_sector   = '0;
      ok_slot     = '0;
      commit      = '0;
      commit.key    = res_ff.key;
      commit.sector = sec_ff;
      commit.kind   = kind_ff;
      unique case (op_ff)
         OP_FIND: begin
            ok = res_ff.hit;
            if (res_ff.hit) begin
               ok_sector = res_ff.hit_sector;
               ok_slot   = res_ff.hit_slot;
            end
         end
         OP_ADD: begin
            ok = !res_ff.hit && res_ff.free_found;
            if (ok) begin
               ok_slot = res_ff.free_slot;
            end
            commit.fill = 1'b1;
            commit.slot = res_ff.free_slot;
            commit.en   = finish && ok;
         end
         OP_REMOVE: begin
            ok = res_ff.hit;
            if (ok) begin
               ok_slot = res_ff.hit_slot;
            end
            commit.fill = 1'b0;
            commit.slot = res_ff.hit_slot;
            commit.en   = finish && ok;
         end
         default: begin
            ok = 1'b0;
         end
      endcase
   end

   assign sec_out_wide = 32'(ok_sector);
   assign slot_wide    = 32'(ok_slot);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = ST_SCAN;
         ST_SCAN: if (chain[TABLE_SLOTS].valid) state_in = ST_DONE;
         ST_DONE: if (rsp_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         active_ff     <= ACTIVE_RESET;
         head_ff.valid <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff.valid <= head_in.valid;
         if (csr_we) begin
            active_ff <= csr_wdata;
         end
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      head_ff.key        <= head_in.key;
      head_ff.remaining  <= head_in.remaining;
      head_ff.hit        <= head_in.hit;
      head_ff.hit_slot   <= head_in.hit_slot;
      head_ff.hit_sector <= head_in.hit_sector;
      head_ff.free_found <= head_in.free_found;
      head_ff.free_slot  <= head_in.free_slot;
      if (accept) begin
         op_ff   <= req_type;
         sec_ff  <= sec_in_wide[SECTOR_BITS-1:0];
         kind_ff <= req_entry_kind;
      end
      if (chain[TABLE_SLOTS].valid) begin
         res_ff <= chain[TABLE_SLOTS];
      end
      if (finish) begin
         rsp_success_ff <= ok;
         rsp_sector_ff  <= sec_out_wide[15:0];
         rsp_slot_ff    <= slot_wide[5:0];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_success    = rsp_success_ff;
   assign rsp_sector_out = rsp_sector_ff;
   assign rsp_slot_index = rsp_slot_ff;

`ifndef SYNTHESIS
   a_tail_only_in_scan: assert property (@(posedge clock) disable iff (reset)
      chain[TABLE_SLOTS].valid |-> state_ff == ST_SCAN)
      else $error("probe left the row outside a scan");

   a_fail_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_success_ff) |-> (rsp_sector_ff == '0 && rsp_slot_ff == '0))
      else $error("failed transaction carries nonzero payload");

   a_commit_reports: assert property (@(posedge clock) disable iff (reset)
      commit.en |=> rsp_valid_ff && rsp_success_ff)
      else $error("table update without a successful response");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready && !head_in.valid)
      else $error("second transaction accepted during a scan");
`endif

endmodule
